// ===== sv/drs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Datetime record sorter package
// Record, neighbor link and control types shared by the sorting cells and
// the top level, and the ordering function used by the cells.
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int unsigned DrsRecords = 32;

  localparam int unsigned OwnerW  = 17;
  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned KeyW    = YearW + MonthW + DayW + HourW + MinuteW;

  typedef struct packed {
    logic [OwnerW-1:0]  owner;
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
  } rec_t;

  // Contents of one cell as seen by its neighbors.
  typedef struct packed {
    logic valid;
    rec_t rec;
  } slot_t;

  // Chain-wide control, the same for every cell.
  typedef struct packed {
    logic ins;  // insert the broadcast record
    logic pop;  // move every record one cell toward the head
  } ctrl_t;

  function automatic logic [KeyW-1:0] rec_key(input rec_t r);
    rec_key = {r.year, r.month, r.day, r.hour, r.minute};
  endfunction

  // True when record a must come strictly after record b. Empty records
  // (owner zero) go after all occupied ones and keep arrival order.
  function automatic logic rec_after(input rec_t a, input rec_t b);
    logic ea;
    logic eb;
    ea = (a.owner == '0);
    eb = (b.owner == '0);
    if (ea != eb) begin
      rec_after = ea;
    end else if (ea) begin
      rec_after = 1'b0;
    end else begin
      rec_after = rec_key(a) > rec_key(b);
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/datetime_record_sorter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Datetime record sorter
// Collects appointment records and emits them sorted by date and time.
// ----------------------------------------------------------------------------
// Records enter on the input channel, one beat per record, and are sorted as
// they arrive by a chain of RECORDS identical cells. Each load cycle the new
// record is broadcast to every cell; each cell compares it with its own record
// and either keeps its record, takes its upstream neighbor's record, or takes
// the new one, so the chain always holds the records in order. Occupied
// records come first, ascending by year, month, day, hour and minute; equal
// keys keep their arrival order. Records with owner number zero are empty and
// follow all occupied ones in arrival order. The input takes a new record
// whenever it is not stalled. A beat with last_record set is itself stored
// and then closes the set: the input stalls and the chain drains from its
// head cell, one output beat per cycle while out_stall is low, with out_last
// on the final one. Each output beat shifts the chain once toward the head.
// When RECORDS records are already held, further records are dropped, but a
// dropped record carrying last_record still starts the emission. There is no
// clearing pass after reset; the block accepts a record in its first cycle.
// ----------------------------------------------------------------------------
module datetime_record_sorter #(
  parameter int unsigned RECORDS = drs_pkg::DrsRecords
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Input channel
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [drs_pkg::OwnerW-1:0]   owner_number_i,
  input  wire  [drs_pkg::YearW-1:0]    year_value_i,
  input  wire  [drs_pkg::MonthW-1:0]   month_value_i,
  input  wire  [drs_pkg::DayW-1:0]     day_value_i,
  input  wire  [drs_pkg::HourW-1:0]    hour_value_i,
  input  wire  [drs_pkg::MinuteW-1:0]  minute_value_i,
  input  wire                          last_record_i,
  // Output channel
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [drs_pkg::OwnerW-1:0]   out_owner_o,
  output logic [drs_pkg::YearW-1:0]    out_year_o,
  output logic [drs_pkg::MonthW-1:0]   out_month_o,
  output logic [drs_pkg::DayW-1:0]     out_day_o,
  output logic [drs_pkg::HourW-1:0]    out_hour_o,
  output logic [drs_pkg::MinuteW-1:0]  out_minute_o,
  output logic                         out_last_o
);

  localparam int unsigned CntW = $clog2(RECORDS + 1);

  // Number of records held; counts down again while the chain drains.
  logic [CntW-1:0] count_q, count_d;
  // High from the closing beat until the final record has left.
  logic            emit_q, emit_d;

  logic            in_acc;
  logic            out_acc;
  logic            has_room;

  drs_pkg::rec_t   new_rec;
  drs_pkg::ctrl_t  ctrl;
  drs_pkg::slot_t  slots [RECORDS];
  logic [RECORDS-1:0] shifts;

  assign in_stall_o = emit_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign has_room   = count_q < CntW'(RECORDS);

  assign new_rec.owner  = owner_number_i;
  assign new_rec.year   = year_value_i;
  assign new_rec.month  = month_value_i;
  assign new_rec.day    = day_value_i;
  assign new_rec.hour   = hour_value_i;
  assign new_rec.minute = minute_value_i;

  assign ctrl.ins = in_acc && has_room;
  assign ctrl.pop = out_acc;

  // Chain of sorting cells; cell 0 is the head and holds the smallest record.
  for (genvar g = 0; g < RECORDS; g++) begin : g_cell
    drs_pkg::slot_t up_slot;
    logic           up_shift;
    drs_pkg::slot_t down_slot;

    if (g == 0) begin : g_head
      assign up_slot  = '0;
      assign up_shift = 1'b0;
    end else begin : g_body
      assign up_slot  = slots[g-1];
      assign up_shift = shifts[g-1];
    end

    if (g == RECORDS - 1) begin : g_tail
      assign down_slot = '0;
    end else begin : g_next
      assign down_slot = slots[g+1];
    end

    drs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_rec_i   (new_rec),
      .up_slot_i   (up_slot),
      .up_shift_i  (up_shift),
      .down_slot_i (down_slot),
      .slot_o      (slots[g]),
      .shift_o     (shifts[g])
    );
  end

  always_comb begin
    count_d = count_q;
    emit_d  = emit_q;
    if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end
    if (in_acc && last_record_i) begin
      emit_d = 1'b1;
    end
    if (out_acc) begin
      count_d = count_q - CntW'(1);
      if (count_q == CntW'(1)) begin
        emit_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      emit_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      emit_q  <= emit_d;
    end
  end

  // The head cell is the output register.
  assign out_valid_o  = emit_q;
  assign out_owner_o  = slots[0].rec.owner;
  assign out_year_o   = slots[0].rec.year;
  assign out_month_o  = slots[0].rec.month;
  assign out_day_o    = slots[0].rec.day;
  assign out_hour_o   = slots[0].rec.hour;
  assign out_minute_o = slots[0].rec.minute;
  assign out_last_o   = emit_q && (count_q == CntW'(1));

  // While draining, the head cell always holds a record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> slots[0].valid)
    else $error("output beat offered from an empty head cell");

  // Draining never runs with an empty chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q |-> (count_q != '0))
    else $error("emission active with no records held");

  // A closing beat starts the emission in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_record_i) |=> emit_q)
    else $error("closing beat did not start the emission");

  // The final output beat empties the chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_last_o) |=> (!emit_q && count_q == '0 && !slots[0].valid))
    else $error("records left after the final output beat");

endmodule
`default_nettype wire

// ===== sv/drs_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Datetime record sorter cell
// One slot of the sorting chain: compares its record with the broadcast one
// and keeps its record or takes the new, the upstream or the downstream one.
// ----------------------------------------------------------------------------
module drs_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire drs_pkg::ctrl_t  ctrl_i,
  input  wire drs_pkg::rec_t   new_rec_i,
  input  wire drs_pkg::slot_t  up_slot_i,
  input  wire                  up_shift_i,
  input  wire drs_pkg::slot_t  down_slot_i,
  output drs_pkg::slot_t       slot_o,
  output logic                 shift_o
);

  logic          valid_q, valid_d;
  drs_pkg::rec_t rec_q, rec_d;

  // The new record belongs ahead of whatever this cell holds.
  assign shift_o = !valid_q || drs_pkg::rec_after(rec_q, new_rec_i);

  always_comb begin
    valid_d = valid_q;
    rec_d   = rec_q;
    if (ctrl_i.pop) begin
      valid_d = down_slot_i.valid;
      rec_d   = down_slot_i.rec;
    end else if (ctrl_i.ins && shift_o) begin
      if (up_shift_i) begin
        valid_d = up_slot_i.valid;
        rec_d   = up_slot_i.rec;
      end else begin
        valid_d = 1'b1;
        rec_d   = new_rec_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign slot_o.valid = valid_q;
  assign slot_o.rec   = rec_q;

endmodule
`default_nettype wire
